### sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMP(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

### sv/lbsm_pkg.sv
`timescale 1ns / 1ps

package lbsm_pkg;

    localparam int LBSM_SLOTS = 8;
    localparam int BLOCK_W    = 16;
    localparam int SLOT_W     = 3;
    localparam int OPCODE_W   = 2;

endpackage

### sv/lru_block_slot_manager.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// in        inbound    in_valid / in_stall  opcode, block_number, slot_index
// out       outbound   out_valid/out_stall  slot, hit, fetch_needed, writeback_valid,
//                                           writeback_block, range_error, last
// cfg       inbound    cfg_valid/cfg_ready  cfg_data (highest_block)
//
// An in-range access reads one slot of the block memory per cycle and compares it in one
// shared compare stage; the update state then commits the choice once the output is free.
// A flush walks the slots in order and reads only the dirty ones through the single read port of the block memory.
// Reset is asynchronous and marks every slot free with rank equal to its index.
// A result waiting in the output register does not block the next transfer in;
// a stalled output only holds the sequencer at its next result.
module lru_block_slot_manager #(
    parameter int SLOTS = lbsm_pkg::LBSM_SLOTS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [lbsm_pkg::OPCODE_W-1:0]      opcode,
    input  logic [lbsm_pkg::BLOCK_W-1:0]       block_number,
    input  logic [lbsm_pkg::SLOT_W-1:0]        slot_index,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [lbsm_pkg::SLOT_W-1:0]        slot,
    output logic                               hit,
    output logic                               fetch_needed,
    output logic                               writeback_valid,
    output logic [lbsm_pkg::BLOCK_W-1:0]       writeback_block,
    output logic                               range_error,
    output logic                               last,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lbsm_pkg::BLOCK_W-1:0]       cfg_data
);
    import lbsm_pkg::*;

`include "assert_macros.svh"

    localparam int IW = $clog2(SLOTS);

    typedef enum logic [OPCODE_W-1:0] {
        OP_ACCESS,
        OP_MARK,
        OP_FLUSH
    } op_t;

    typedef enum logic [1:0] {
        ST_FREE,
        ST_FULL,
        ST_DIRTY
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE,
        S_FSCAN,
        S_FEMIT,
        S_ONE
    } state_t;

    function automatic logic [SLOT_W-1:0] to_slot(input logic [IW-1:0] idx);
        logic [IW+SLOT_W-1:0] w;
        w = (IW + SLOT_W)'(idx);
        return w[SLOT_W-1:0];
    endfunction

    state_t              state_reg;
    status_t             status_reg [SLOTS];
    logic [BLOCK_W-1:0]  hb_reg;
    logic [BLOCK_W-1:0]  bn_reg;
    logic [IW:0]         cnt_reg;
    logic                cmp_valid_reg;
    logic [IW-1:0]       cmp_idx_reg;
    logic                hit_found_reg;
    logic [IW-1:0]       hit_idx_reg;
    logic                free_found_reg;
    logic [IW-1:0]       free_idx_reg;
    logic [IW-1:0]       max_rank_reg;
    logic [IW-1:0]       max_idx_reg;
    logic [BLOCK_W-1:0]  max_block_reg;
    logic                one_range_reg;

    logic                out_valid_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic                hit_reg;
    logic                fetch_reg;
    logic                wbv_reg;
    logic [BLOCK_W-1:0]  wbb_reg;
    logic                range_reg;
    logic                last_reg;

    logic                in_accept;
    logic                out_free;
    logic                out_load;
    logic [IW-1:0]       cnt_idx;
    logic                cnt_in_range;
    logic                mem_wr_en;
    logic                mem_rd_en;
    logic [BLOCK_W-1:0]  mem_rd_data;
    logic [IW-1:0]       rank_rd;
    logic                touch_en;
    logic [IW-1:0]       sel_idx;
    logic                victim_dirty;
    logic                any_dirty;
    logic                later_dirty;
    logic [IW+SLOT_W-1:0] si_wide;
    logic [IW-1:0]       si_idx;
    logic                si_ok;
    logic                cmp_free;

    assign in_stall     = (state_reg != S_IDLE);
    assign in_accept    = in_valid && !in_stall;
    assign out_free     = !out_valid_reg || !out_stall;
    assign out_load     = out_free && ((state_reg == S_UPDATE) || (state_reg == S_FEMIT)
                                       || (state_reg == S_ONE));
    assign cfg_ready    = 1'b1;
    assign cnt_idx      = cnt_reg[IW-1:0];
    assign cnt_in_range = (cnt_reg < (IW + 1)'(SLOTS));

    assign si_wide = (IW + SLOT_W)'(slot_index);
    assign si_idx  = si_wide[IW-1:0];
    assign si_ok   = (si_wide < (IW + SLOT_W)'(SLOTS));

    assign cmp_free = (status_reg[cmp_idx_reg] == ST_FREE);

    always_comb
    begin
        priority if (hit_found_reg)
        begin
            sel_idx = hit_idx_reg;
        end
        else if (free_found_reg)
        begin
            sel_idx = free_idx_reg;
        end
        else
        begin
            sel_idx = max_idx_reg;
        end
    end

    assign victim_dirty = !hit_found_reg && !free_found_reg
                          && (status_reg[max_idx_reg] == ST_DIRTY);

    always_comb
    begin
        any_dirty   = 1'b0;
        later_dirty = 1'b0;
        for (int j = 0; j < SLOTS; j++)
        begin
            if (status_reg[j] == ST_DIRTY)
            begin
                any_dirty = 1'b1;
                if ((IW + 1)'(j) > cnt_reg)
                begin
                    later_dirty = 1'b1;
                end
            end
        end
    end

    assign mem_rd_en = ((state_reg == S_SCAN) && cnt_in_range)
                       || ((state_reg == S_FSCAN) && (status_reg[cnt_idx] == ST_DIRTY));
    assign touch_en  = (state_reg == S_UPDATE) && out_free;
    assign mem_wr_en = touch_en && !hit_found_reg;

    lbsm_block_mem #(
        .SLOTS(SLOTS)
    ) u_block_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (sel_idx),
        .wr_data (bn_reg),
        .rd_en   (mem_rd_en),
        .rd_addr (cnt_idx),
        .rd_data (mem_rd_data)
    );

    lbsm_rank_file #(
        .SLOTS(SLOTS)
    ) u_rank_file (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_idx    (cmp_idx_reg),
        .rd_rank   (rank_rd),
        .touch_en  (touch_en),
        .touch_idx (sel_idx)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            for (int i = 0; i < SLOTS; i++)
            begin
                status_reg[i] <= ST_FREE;
            end
            hb_reg         <= '0;
            bn_reg         <= '0;
            cnt_reg        <= '0;
            cmp_valid_reg  <= 1'b0;
            cmp_idx_reg    <= '0;
            hit_found_reg  <= 1'b0;
            hit_idx_reg    <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            max_rank_reg   <= '0;
            max_idx_reg    <= '0;
            max_block_reg  <= '0;
            one_range_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            slot_reg       <= '0;
            hit_reg        <= 1'b0;
            fetch_reg      <= 1'b0;
            wbv_reg        <= 1'b0;
            wbb_reg        <= '0;
            range_reg      <= 1'b0;
            last_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                hb_reg <= cfg_data;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        unique case (op_t'(opcode))
                            OP_ACCESS:
                            begin
                                if (block_number > hb_reg)
                                begin
                                    one_range_reg <= 1'b1;
                                    state_reg     <= S_ONE;
                                end
                                else
                                begin
                                    bn_reg         <= block_number;
                                    cnt_reg        <= '0;
                                    cmp_valid_reg  <= 1'b0;
                                    hit_found_reg  <= 1'b0;
                                    free_found_reg <= 1'b0;
                                    state_reg      <= S_SCAN;
                                end
                            end
                            OP_MARK:
                            begin
                                if (si_ok && (status_reg[si_idx] != ST_FREE))
                                begin
                                    status_reg[si_idx] <= ST_DIRTY;
                                end
                            end
                            OP_FLUSH:
                            begin
                                cnt_reg <= '0;
                                if (any_dirty)
                                begin
                                    state_reg <= S_FSCAN;
                                end
                                else
                                begin
                                    one_range_reg <= 1'b0;
                                    state_reg     <= S_ONE;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end

                S_SCAN:
                begin
                    if (cmp_valid_reg)
                    begin
                        if (!cmp_free && (mem_rd_data == bn_reg) && !hit_found_reg)
                        begin
                            hit_found_reg <= 1'b1;
                            hit_idx_reg   <= cmp_idx_reg;
                        end
                        if (cmp_free && !free_found_reg)
                        begin
                            free_found_reg <= 1'b1;
                            free_idx_reg   <= cmp_idx_reg;
                        end
                        if ((cmp_idx_reg == '0) || (rank_rd > max_rank_reg))
                        begin
                            max_rank_reg  <= rank_rd;
                            max_idx_reg   <= cmp_idx_reg;
                            max_block_reg <= mem_rd_data;
                        end
                    end
                    if (cnt_in_range)
                    begin
                        cmp_valid_reg <= 1'b1;
                        cmp_idx_reg   <= cnt_idx;
                        cnt_reg       <= cnt_reg + (IW + 1)'(1);
                    end
                    else
                    begin
                        cmp_valid_reg <= 1'b0;
                    end
                    if (cmp_valid_reg && (cmp_idx_reg == IW'(SLOTS - 1)))
                    begin
                        state_reg <= S_UPDATE;
                    end
                end

                S_UPDATE:
                begin
                    if (out_free)
                    begin
                        slot_reg      <= to_slot(sel_idx);
                        hit_reg       <= hit_found_reg;
                        fetch_reg     <= !hit_found_reg;
                        wbv_reg       <= victim_dirty;
                        wbb_reg       <= victim_dirty ? max_block_reg : '0;
                        range_reg     <= 1'b0;
                        last_reg      <= 1'b1;
                        if (!hit_found_reg)
                        begin
                            status_reg[sel_idx] <= ST_FULL;
                        end
                        state_reg <= S_IDLE;
                    end
                end

                S_FSCAN:
                begin
                    if (status_reg[cnt_idx] == ST_DIRTY)
                    begin
                        state_reg <= S_FEMIT;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + (IW + 1)'(1);
                    end
                end

                S_FEMIT:
                begin
                    if (out_free)
                    begin
                        slot_reg            <= to_slot(cnt_idx);
                        hit_reg             <= 1'b0;
                        fetch_reg           <= 1'b0;
                        wbv_reg             <= 1'b1;
                        wbb_reg             <= mem_rd_data;
                        range_reg           <= 1'b0;
                        last_reg            <= !later_dirty;
                        status_reg[cnt_idx] <= ST_FULL;
                        cnt_reg             <= cnt_reg + (IW + 1)'(1);
                        state_reg           <= later_dirty ? S_FSCAN : S_IDLE;
                    end
                end

                S_ONE:
                begin
                    if (out_free)
                    begin
                        slot_reg      <= '0;
                        hit_reg       <= 1'b0;
                        fetch_reg     <= 1'b0;
                        wbv_reg       <= 1'b0;
                        wbb_reg       <= '0;
                        range_reg     <= one_range_reg;
                        last_reg      <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid       = out_valid_reg;
    assign slot            = slot_reg;
    assign hit             = hit_reg;
    assign fetch_needed    = fetch_reg;
    assign writeback_valid = wbv_reg;
    assign writeback_block = wbb_reg;
    assign range_error     = range_reg;
    assign last            = last_reg;

    `ASSERT_IMP(a_range_alone, out_valid_reg && range_reg,
                last_reg && !hit_reg && !fetch_reg && !wbv_reg,
                "range error result carries other flags")
    `ASSERT_IMP(a_hit_no_fetch, out_valid_reg && hit_reg, !fetch_reg && !wbv_reg,
                "hit result also fetches or writes back")
    `ASSERT_NXT(a_femit_cleans, (state_reg == S_FEMIT) && out_free,
                status_reg[$past(cnt_idx)] == ST_FULL, "flushed slot still dirty")

endmodule

### sv/lbsm_block_mem.sv
`timescale 1ns / 1ps

module lbsm_block_mem #(
    parameter int SLOTS = lbsm_pkg::LBSM_SLOTS
) (
    input  logic                                 clk,
    input  logic                                 wr_en,
    input  logic [$clog2(SLOTS)-1:0]             wr_addr,
    input  logic [lbsm_pkg::BLOCK_W-1:0]         wr_data,
    input  logic                                 rd_en,
    input  logic [$clog2(SLOTS)-1:0]             rd_addr,
    output logic [lbsm_pkg::BLOCK_W-1:0]         rd_data
);
    import lbsm_pkg::*;

    logic [BLOCK_W-1:0] mem [SLOTS];
    logic [BLOCK_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/lbsm_rank_file.sv
`timescale 1ns / 1ps

module lbsm_rank_file #(
    parameter int SLOTS = lbsm_pkg::LBSM_SLOTS
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [$clog2(SLOTS)-1:0] rd_idx,
    output logic [$clog2(SLOTS)-1:0] rd_rank,
    input  logic                     touch_en,
    input  logic [$clog2(SLOTS)-1:0] touch_idx
);
    import lbsm_pkg::*;

`include "assert_macros.svh"

    localparam int IW = $clog2(SLOTS);

    logic [IW-1:0] rank_reg  [SLOTS];
    logic [IW-1:0] rank_next [SLOTS];
    logic [IW-1:0] touch_rank;

    assign touch_rank = rank_reg[touch_idx];
    assign rd_rank    = rank_reg[rd_idx];

    // Touching a slot makes it the newest; every slot that was newer ages by one.
    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            rank_next[i] = rank_reg[i];
            if (touch_en)
            begin
                if (IW'(i) == touch_idx)
                begin
                    rank_next[i] = '0;
                end
                else if (rank_reg[i] < touch_rank)
                begin
                    rank_next[i] = rank_reg[i] + IW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                rank_reg[i] <= IW'(i);
            end
        end
        else
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    `ASSERT_NXT(a_touch_newest, touch_en, rank_reg[$past(touch_idx)] == '0, "touched slot is not newest")
    `ASSERT_NXT(a_touch_keeps_older, touch_en && (rd_idx != touch_idx) && (rd_rank > touch_rank), $stable(rank_reg[rd_idx]) || (rd_idx != $past(rd_idx)), "older slot changed rank")

endmodule

### tb/lbsm_tb_pkg.sv
`timescale 1ns / 1ps

package lbsm_tb_pkg;

    typedef enum logic [1:0] {
        OP_ACCESS     = 2'd0,
        OP_MARK_DIRTY = 2'd1,
        OP_FLUSH      = 2'd2,
        OP_UNUSED     = 2'd3
    } lbsm_op_e;

endpackage

### tb/lbsm_checker.sv
`timescale 1ns / 1ps

module lbsm_checker
    import lbsm_tb_pkg::*;
#(
    parameter int SLOTS = lbsm_pkg::LBSM_SLOTS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  logic [lbsm_pkg::OPCODE_W-1:0]      opcode,
    input  logic [lbsm_pkg::BLOCK_W-1:0]       block_number,
    input  logic [lbsm_pkg::SLOT_W-1:0]        slot_index,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  logic [lbsm_pkg::SLOT_W-1:0]        slot,
    input  logic                               hit,
    input  logic                               fetch_needed,
    input  logic                               writeback_valid,
    input  logic [lbsm_pkg::BLOCK_W-1:0]       writeback_block,
    input  logic                               range_error,
    input  logic                               last,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [lbsm_pkg::BLOCK_W-1:0]       cfg_data,
    output int                                 mismatches,
    output int                                 outstanding
);

    typedef enum logic [1:0] {
        SLOT_FREE  = 2'd0,
        SLOT_FULL  = 2'd1,
        SLOT_DIRTY = 2'd2
    } slot_state_e;

    typedef struct packed {
        logic [lbsm_pkg::SLOT_W-1:0]  slot;
        logic                         hit;
        logic                         fetch_needed;
        logic                         writeback_valid;
        logic [lbsm_pkg::BLOCK_W-1:0] writeback_block;
        logic                         range_error;
        logic                         last;
    } slot_result_t;

    logic [lbsm_pkg::BLOCK_W-1:0] highest_block;
    logic [lbsm_pkg::BLOCK_W-1:0] held_block [SLOTS];
    slot_state_e                  slot_state [SLOTS];
    logic [lbsm_pkg::SLOT_W-1:0]  age        [SLOTS];
    slot_result_t                 expected_q [$];

    function automatic string show(input slot_result_t r);
        return $sformatf("slot=%0d hit=%0b fetch=%0b wb_valid=%0b wb_block=%h rerr=%0b last=%0b",
                         r.slot, r.hit, r.fetch_needed, r.writeback_valid,
                         r.writeback_block, r.range_error, r.last);
    endfunction

    function automatic void flag_mismatch(input string what, input slot_result_t want,
                                          input slot_result_t got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%t: %s", $realtime, what);
            $display("    expected %s", show(want));
            $display("    actual   %s", show(got));
        end
    endfunction

    // The touched slot becomes the newest and every slot younger than it ages by one.
    function automatic void promote(input int s);
        logic [lbsm_pkg::SLOT_W-1:0] r;
        r = age[s];
        for (int i = 0; i < SLOTS; i++) begin
            if (age[i] < r) begin
                age[i] = age[i] + 1'b1;
            end
        end
        age[s] = '0;
    endfunction

    function automatic void predict_access(input logic [lbsm_pkg::BLOCK_W-1:0] bn);
        int           s;
        slot_result_t r;
        s = -1;
        r = '0;
        r.last = 1'b1;
        if (bn > highest_block) begin
            r.range_error = 1'b1;
            expected_q.push_back(r);
            return;
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (s < 0 && slot_state[i] != SLOT_FREE && held_block[i] == bn) begin
                s = i;
            end
        end
        if (s >= 0) begin
            promote(s);
            r.slot = lbsm_pkg::SLOT_W'(s);
            r.hit  = 1'b1;
            expected_q.push_back(r);
            return;
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (s < 0 && slot_state[i] == SLOT_FREE) begin
                s = i;
            end
        end
        if (s < 0) begin
            s = 0;
            for (int i = 1; i < SLOTS; i++) begin
                if (age[i] > age[s]) begin
                    s = i;
                end
            end
            if (slot_state[s] == SLOT_DIRTY) begin
                r.writeback_valid = 1'b1;
                r.writeback_block = held_block[s];
            end
        end
        slot_state[s] = SLOT_FULL;
        held_block[s] = bn;
        promote(s);
        r.slot         = lbsm_pkg::SLOT_W'(s);
        r.fetch_needed = 1'b1;
        expected_q.push_back(r);
    endfunction

    function automatic void predict_flush();
        int           n;
        slot_result_t r;
        n = 0;
        for (int i = 0; i < SLOTS; i++) begin
            if (slot_state[i] == SLOT_DIRTY) begin
                r = '0;
                r.slot            = lbsm_pkg::SLOT_W'(i);
                r.writeback_valid = 1'b1;
                r.writeback_block = held_block[i];
                expected_q.push_back(r);
                slot_state[i] = SLOT_FULL;
                n++;
            end
        end
        if (n == 0) begin
            r = '0;
        end else begin
            r = expected_q.pop_back();
        end
        r.last = 1'b1;
        expected_q.push_back(r);
    endfunction

    always @(posedge clk or negedge rst_n) begin
        slot_result_t got;
        slot_result_t want;
        if (!rst_n) begin
            highest_block = '0;
            for (int i = 0; i < SLOTS; i++) begin
                held_block[i] = '0;
                slot_state[i] = SLOT_FREE;
                age[i]        = lbsm_pkg::SLOT_W'(i);
            end
            expected_q.delete();
            outstanding = 0;
        end else begin
            if (out_valid && !out_stall) begin
                got = {slot, hit, fetch_needed, writeback_valid, writeback_block,
                       range_error, last};
                if (expected_q.size() == 0) begin
                    flag_mismatch("result transfer with nothing expected", '0, got);
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        flag_mismatch("result transfer differs", want, got);
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                highest_block = cfg_data;
            end
            if (in_valid && !in_stall) begin
                case (lbsm_op_e'(opcode))
                    OP_ACCESS: predict_access(block_number);
                    OP_MARK_DIRTY: begin
                        if (int'(slot_index) < SLOTS && slot_state[slot_index] != SLOT_FREE) begin
                            slot_state[slot_index] = SLOT_DIRTY;
                        end
                    end
                    OP_FLUSH: predict_flush();
                    default: ;
                endcase
            end
            outstanding = expected_q.size();
        end
    end

endmodule

### tb/lru_block_slot_manager_tb.sv
`timescale 1ns / 1ps

module lru_block_slot_manager_tb;
    import lbsm_tb_pkg::*;

    localparam int LIMIT     = 400000;
    localparam int SETTLE    = 40;
    localparam int LONG_HOLD = 300;
    localparam int POOL      = 12;

    logic                          clk             = 1'b0;
    logic                          rst_n           = 1'b0;
    logic                          in_valid        = 1'b0;
    logic                          in_stall;
    logic [lbsm_pkg::OPCODE_W-1:0] opcode          = '0;
    logic [lbsm_pkg::BLOCK_W-1:0]  block_number    = '0;
    logic [lbsm_pkg::SLOT_W-1:0]   slot_index      = '0;
    logic                          out_valid;
    logic                          out_stall       = 1'b0;
    logic [lbsm_pkg::SLOT_W-1:0]   slot;
    logic                          hit;
    logic                          fetch_needed;
    logic                          writeback_valid;
    logic [lbsm_pkg::BLOCK_W-1:0]  writeback_block;
    logic                          range_error;
    logic                          last;
    logic                          cfg_valid       = 1'b0;
    logic                          cfg_ready;
    logic [lbsm_pkg::BLOCK_W-1:0]  cfg_data        = '0;

    int                            mismatches;
    int                            outstanding;
    int unsigned                   cycles          = 0;
    bit                            calm            = 1'b0;
    bit                            hold_long       = 1'b0;
    logic [lbsm_pkg::BLOCK_W-1:0]  block_pool [POOL];

    always #1 clk = ~clk;

    lru_block_slot_manager dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .opcode          (opcode),
        .block_number    (block_number),
        .slot_index      (slot_index),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .slot            (slot),
        .hit             (hit),
        .fetch_needed    (fetch_needed),
        .writeback_valid (writeback_valid),
        .writeback_block (writeback_block),
        .range_error     (range_error),
        .last            (last),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    lbsm_checker u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .opcode          (opcode),
        .block_number    (block_number),
        .slot_index      (slot_index),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .slot            (slot),
        .hit             (hit),
        .fetch_needed    (fetch_needed),
        .writeback_valid (writeback_valid),
        .writeback_block (writeback_block),
        .range_error     (range_error),
        .last            (last),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .outstanding     (outstanding)
    );

    initial begin
        while (cycles < LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    initial begin
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_long) begin
                hold_long = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                out_stall <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(negedge clk);
                out_stall <= 1'b0;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Returns at the falling edge after the transfer with valid still high.
    task automatic send_item(input lbsm_op_e op, input logic [lbsm_pkg::BLOCK_W-1:0] bn,
                             input logic [lbsm_pkg::SLOT_W-1:0] si);
        if (!calm && $urandom_range(0, 7) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        in_valid     <= 1'b1;
        opcode       <= op;
        block_number <= bn;
        slot_index   <= si;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_highest(input logic [lbsm_pkg::BLOCK_W-1:0] value);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int count, input int unsigned highest, input bit with_hold);
        int unsigned pick;
        logic [lbsm_pkg::BLOCK_W-1:0] bn;
        write_highest(lbsm_pkg::BLOCK_W'(highest));
        for (int k = 0; k < POOL; k++) begin
            block_pool[k] = lbsm_pkg::BLOCK_W'($urandom_range(0, highest));
        end
        for (int n = 0; n < count; n++) begin
            if (with_hold && n == count / 3) begin
                hold_long = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 58) begin
                send_item(OP_ACCESS, block_pool[$urandom_range(0, POOL - 1)], 3'($urandom));
            end else if (pick < 68) begin
                if (highest == 32'hFFFF) begin
                    bn = 16'($urandom);
                end else begin
                    bn = 16'($urandom_range(highest + 1, 32'hFFFF));
                end
                send_item(OP_ACCESS, bn, 3'($urandom));
            end else if (pick < 83) begin
                send_item(OP_MARK_DIRTY, 16'($urandom), 3'($urandom));
            end else if (pick < 96) begin
                send_item(OP_FLUSH, 16'($urandom), 3'($urandom));
            end else begin
                send_item(OP_UNUSED, 16'($urandom), 3'($urandom));
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Only block zero is valid right after reset.
        send_item(OP_ACCESS, 16'h0000, 3'd7);
        send_item(OP_ACCESS, 16'h0000, 3'd0);
        send_item(OP_ACCESS, 16'h0001, 3'd0);
        send_item(OP_ACCESS, 16'hFFFF, 3'd7);
        send_item(OP_MARK_DIRTY, 16'hFFFF, 3'd0);
        send_item(OP_MARK_DIRTY, 16'h0000, 3'd5);
        send_item(OP_FLUSH, 16'h0000, 3'd0);
        send_item(OP_FLUSH, 16'hFFFF, 3'd7);
        send_item(OP_UNUSED, 16'hFFFF, 3'd7);

        write_highest(16'hFFFF);
        send_item(OP_ACCESS, 16'hFFFF, 3'd0);
        send_item(OP_ACCESS, 16'hAAAA, 3'd0);
        send_item(OP_ACCESS, 16'h5555, 3'd0);
        send_item(OP_ACCESS, 16'h0001, 3'd0);
        send_item(OP_ACCESS, 16'h0002, 3'd0);
        send_item(OP_ACCESS, 16'h0003, 3'd0);
        send_item(OP_ACCESS, 16'h8000, 3'd0);
        send_item(OP_MARK_DIRTY, 16'h0000, 3'd0);
        send_item(OP_ACCESS, 16'h1234, 3'd0);
        for (int i = 0; i < lbsm_pkg::LBSM_SLOTS; i++) begin
            send_item(OP_MARK_DIRTY, 16'h0000, 3'(i));
        end
        send_item(OP_FLUSH, 16'h0000, 3'd0);

        run_phase(100, 20, 1'b0);
        run_phase(110, 32'hFFFF, 1'b1);
        run_phase(90, $urandom_range(8, 40), 1'b0);
        run_phase(40, 0, 1'b0);
        calm = 1'b1;
        run_phase(110, 100, 1'b0);

        settle();
        if (mismatches == 0 && outstanding == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
